// ----- design/vpi_pkg.sv -----
// Package for the voxel palette indexer: the beat record that travels down
// the palette cell chain and the configuration register indexes.
// No dependencies.
package vpi_pkg;

	localparam logic [1:0] CFG_SWAP_RED_BLUE = 2'd0;
	localparam logic [1:0] CFG_EXTENT_X      = 2'd1;
	localparam logic [1:0] CFG_EXTENT_Y      = 2'd2;
	localparam logic [1:0] CFG_EXTENT_Z      = 2'd3;

	typedef struct packed {
		logic        valid;
		logic        active;
		logic [23:0] rgb;
		logic        hit;
		logic [7:0]  idx;
		logic        fresh;
		logic [23:0] addr;
		logic        last;
	} item_t;

endpackage

// ----- design/vpi_if.sv -----
// Channel interfaces for the voxel palette indexer: voxel color beats in,
// palette result beats out. No dependencies.
interface vpi_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic [7:0] alpha;

	modport source (output valid, red, green, blue, alpha, input ready);
	modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface vpi_out_if;
	logic        valid;
	logic        ready;
	logic        store;
	logic [23:0] voxel_address;
	logic [7:0]  palette_index;
	logic        new_entry;
	logic [7:0]  entry_red;
	logic [7:0]  entry_green;
	logic [7:0]  entry_blue;
	logic        palette_full;
	logic        last_voxel;

	modport source (output valid, store, voxel_address, palette_index, new_entry,
		entry_red, entry_green, entry_blue, palette_full, last_voxel, input ready);
	modport sink (input valid, store, voxel_address, palette_index, new_entry,
		entry_red, entry_green, entry_blue, palette_full, last_voxel, output ready);
endinterface

// ----- design/vpi_addr.sv -----
// Scan position counters and the two-stage voxel address pipeline that feeds
// the palette cell chain. Depends on vpi_pkg.
module vpi_addr #(
	parameter int MAX_EXTENT = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          accept,
	input  logic          swap,
	input  logic [8:0]    extent_x,
	input  logic [8:0]    extent_y,
	input  logic [8:0]    extent_z,
	input  logic [7:0]    red,
	input  logic [7:0]    green,
	input  logic [7:0]    blue,
	input  logic [7:0]    alpha,
	output vpi_pkg::item_t item
);
	import vpi_pkg::*;

	localparam logic [8:0] EXT_MAX = 9'(MAX_EXTENT);

	logic [7:0]  x_q, y_q, z_q;
	logic [8:0]  ex, ey, ez;
	logic        last_x, last_y, last_z;
	logic [16:0] xy_s1, yz_s1;
	logic [7:0]  z_s1;
	logic [8:0]  ez_s1;
	logic        valid_s1, active_s1, last_s1;
	logic [23:0] rgb_s1;
	logic [23:0] prod;
	item_t       item_s2;

	function automatic logic [8:0] clamp(input logic [8:0] e);
		logic [8:0] r;
		r = e;
		if (e == 9'd0) r = 9'd1;
		else if (e > EXT_MAX) r = EXT_MAX;
		return r;
	endfunction

	assign ex = clamp(extent_x);
	assign ey = clamp(extent_y);
	assign ez = clamp(extent_z);
	assign last_x = ({1'b0, x_q} + 9'd1) >= ex;
	assign last_y = ({1'b0, y_q} + 9'd1) >= ey;
	assign last_z = ({1'b0, z_q} + 9'd1) >= ez;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
			y_q <= '0;
			z_q <= '0;
		end else if (accept) begin
			if (!last_x) begin
				x_q <= x_q + 8'd1;
			end else begin
				x_q <= '0;
				if (!last_y) begin
					y_q <= y_q + 8'd1;
				end else begin
					y_q <= '0;
					z_q <= last_z ? 8'd0 : z_q + 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xy_s1     <= 17'(x_q * ey);
			yz_s1     <= 17'(y_q * ez);
			z_s1      <= z_q;
			ez_s1     <= ez;
			active_s1 <= alpha != 8'd0;
			last_s1   <= last_x && last_y && last_z;
			rgb_s1    <= swap ? {blue, green, red} : {red, green, blue};
		end
	end

	assign prod = 24'(xy_s1 * ez_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_s2 <= '0;
		end else if (adv) begin
			item_s2.valid  <= valid_s1;
			item_s2.active <= active_s1;
			item_s2.rgb    <= rgb_s1;
			item_s2.hit    <= 1'b0;
			item_s2.idx    <= '0;
			item_s2.fresh  <= 1'b0;
			item_s2.addr   <= prod + 24'(yz_s1) + 24'(z_s1);
			item_s2.last   <= last_s1;
		end
	end

	assign item = item_s2;

endmodule

// ----- design/vpi_cell.sv -----
// One palette cell: holds one palette entry and its occupancy, matches or
// claims the entry for the passing beat and hands it on. Depends on vpi_pkg.
module vpi_cell #(
	parameter int INDEX = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  vpi_pkg::item_t item_i,
	output vpi_pkg::item_t item_o
);
	import vpi_pkg::*;

	logic        used_q;
	logic [23:0] color_q;
	item_t       item_q;
	item_t       item_next;
	logic        looking, match, claim;

	assign looking = item_i.valid && item_i.active && !item_i.hit;
	assign match   = looking && used_q && (color_q == item_i.rgb);
	assign claim   = looking && !used_q;

	always_comb begin
		item_next = item_i;
		if (match || claim) begin
			item_next.hit = 1'b1;
			item_next.idx = 8'(INDEX);
		end
		if (claim) begin
			item_next.fresh = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (adv && claim) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && claim) begin
			color_q <= item_i.rgb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q <= '0;
		end else if (adv) begin
			item_q <= item_next;
		end
	end

	assign item_o = item_q;

endmodule

// ----- design/vpi_out.sv -----
// Output register stage: keeps the sticky palette-full flag, forms the result
// beat and drives the stall for the whole chain. Depends on vpi_pkg, vpi_if.
module vpi_out (
	input  logic           clk,
	input  logic           arst_n,
	input  vpi_pkg::item_t item,
	output logic           adv,
	vpi_out_if.source      result
);
	import vpi_pkg::*;

	logic valid_q, err_q, err_next, store;

	assign adv      = !valid_q || result.ready;
	assign err_next = err_q || (item.valid && item.active && !item.hit);
	assign store    = item.active && item.hit && !err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			err_q   <= 1'b0;
		end else if (adv) begin
			valid_q <= item.valid;
			if (item.valid) begin
				err_q <= err_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && item.valid) begin
			result.store         <= store;
			result.voxel_address <= item.addr;
			result.palette_index <= store ? item.idx : 8'd0;
			result.new_entry     <= store && item.fresh;
			result.entry_red     <= store ? item.rgb[23:16] : 8'd0;
			result.entry_green   <= store ? item.rgb[15:8] : 8'd0;
			result.entry_blue    <= store ? item.rgb[7:0] : 8'd0;
			result.palette_full  <= err_next;
			result.last_voxel    <= item.last;
		end
	end

	assign result.valid = valid_q;

endmodule

// ----- design/voxel_palette_indexer.sv -----
// Voxel palette indexer, top level: configuration registers, address pipeline,
// palette cell chain and output stage. Depends on vpi_pkg, vpi_if, vpi_addr,
// vpi_cell and vpi_out.
//
// Usage: each beat on the voxel channel carries one RGBA color, in scan order
// with x innermost, then y, then z. Each accepted beat yields exactly one beat
// on the result channel, in order, with the palette index and voxel address.
// Registers (swap, three extents) are written through cfg_we/cfg_index/
// cfg_data while no beat is in flight.
// An accepted voxel beat passes through two address stages, one cell per
// palette entry and the output register. A new beat is taken every cycle
// unless the receiver stalls the output; each cell compares and claims its
// own entry as a beat passes, so later beats see earlier insertions in order.
// Reset clears the scan counters, all cell occupancy and the palette-full
// flag; no clearing pass is needed. When the receiver stalls, the output
// register holds its beat and the whole chain, including voxel ready, stops.
module voxel_palette_indexer #(
	parameter int PALETTE_SLOTS = 255,
	parameter int MAX_EXTENT    = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [8:0] cfg_data,
	vpi_in_if.sink     voxel,
	vpi_out_if.source  result
);
	import vpi_pkg::*;

	logic       swap_q;
	logic [8:0] ext_x_q, ext_y_q, ext_z_q;
	logic       adv, accept;
	item_t      chain [PALETTE_SLOTS + 1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			swap_q  <= 1'b0;
			ext_x_q <= 9'd1;
			ext_y_q <= 9'd1;
			ext_z_q <= 9'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SWAP_RED_BLUE: swap_q  <= cfg_data[0];
				CFG_EXTENT_X:      ext_x_q <= cfg_data;
				CFG_EXTENT_Y:      ext_y_q <= cfg_data;
				CFG_EXTENT_Z:      ext_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign voxel.ready = adv;
	assign accept      = voxel.valid && adv;

	vpi_addr #(
		.MAX_EXTENT(MAX_EXTENT)
	) u_addr (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.accept(accept),
		.swap(swap_q),
		.extent_x(ext_x_q),
		.extent_y(ext_y_q),
		.extent_z(ext_z_q),
		.red(voxel.red),
		.green(voxel.green),
		.blue(voxel.blue),
		.alpha(voxel.alpha),
		.item(chain[0])
	);

	for (genvar k = 0; k < PALETTE_SLOTS; k++) begin : g_cell
		vpi_cell #(
			.INDEX(k + 1)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.adv(adv),
			.item_i(chain[k]),
			.item_o(chain[k + 1])
		);
	end

	vpi_out u_out (
		.clk(clk),
		.arst_n(arst_n),
		.item(chain[PALETTE_SLOTS]),
		.adv(adv),
		.result(result)
	);

endmodule

// ----- sim/tb_voxel_palette_indexer.sv -----
// Self-checking testbench for voxel_palette_indexer: a directed table, then
// random voxel phases under changing volume settings, checked beat by beat
// against a behavioral palette model. Depends on vpi_pkg, vpi_if and voxel_palette_indexer.
`timescale 1ns / 1ps

module tb_voxel_palette_indexer;
	import vpi_pkg::*;

	localparam int PALETTE_SLOTS = 255;
	localparam int MAX_EXTENT = 256;
	localparam int POOL_COLORS = 80;
	localparam int PHASES = 25;
	localparam int STEADY_PHASE = 3;
	localparam int HOLD_PHASE = 6;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 1000000;

	typedef struct packed {
		logic        store;
		logic [23:0] address;
		logic [7:0]  index;
		logic        fresh;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        full;
		logic        last;
	} voxel_result_t;

	typedef struct packed {
		logic          typed;
		voxel_result_t want;
	} typed_result_t;

	typedef enum logic [1:0] {ROW_REG, ROW_VOXEL, ROW_TYPED} row_kind_e;

	// Register rows carry the write data in the low bits of the payload;
	// voxel rows carry red, green, blue and alpha from the top byte down.
	typedef struct packed {
		row_kind_e     kind;
		logic [1:0]    reg_idx;
		logic [31:0]   payload;
		voxel_result_t want;
	} step_row_t;

	step_row_t directed_rows [32] = '{
		'{ROW_TYPED, '0, 32'h00000000, '{0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 1}},
		'{ROW_TYPED, '0, 32'h000000ff, '{1, 0, 1, 1, 8'h00, 8'h00, 8'h00, 0, 1}},
		'{ROW_TYPED, '0, 32'hffffff01, '{1, 0, 2, 1, 8'hff, 8'hff, 8'hff, 0, 1}},
		'{ROW_TYPED, '0, 32'h00000080, '{1, 0, 1, 0, 8'h00, 8'h00, 8'h00, 0, 1}},
		'{ROW_TYPED, '0, 32'hffffffff, '{1, 0, 2, 0, 8'hff, 8'hff, 8'hff, 0, 1}},
		'{ROW_TYPED, '0, 32'h12345600, '{0, 0, 0, 0, 8'h00, 8'h00, 8'h00, 0, 1}},
		'{ROW_REG, CFG_SWAP_RED_BLUE, 32'd1, '0},
		'{ROW_TYPED, '0, 32'h112233ff, '{1, 0, 3, 1, 8'h33, 8'h22, 8'h11, 0, 1}},
		'{ROW_TYPED, '0, 32'h332211ff, '{1, 0, 4, 1, 8'h11, 8'h22, 8'h33, 0, 1}},
		'{ROW_TYPED, '0, 32'h112233fe, '{1, 0, 3, 0, 8'h33, 8'h22, 8'h11, 0, 1}},
		'{ROW_REG, CFG_SWAP_RED_BLUE, 32'h1fe, '0},
		'{ROW_TYPED, '0, 32'h332211ff, '{1, 0, 3, 0, 8'h33, 8'h22, 8'h11, 0, 1}},
		'{ROW_REG, CFG_EXTENT_X, 32'd0, '0},
		'{ROW_REG, CFG_EXTENT_Y, 32'd2, '0},
		'{ROW_REG, CFG_EXTENT_Z, 32'd257, '0},
		'{ROW_VOXEL, '0, 32'h80808080, '0},
		'{ROW_VOXEL, '0, 32'h7f7f7f7f, '0},
		'{ROW_VOXEL, '0, 32'h01020304, '0},
		'{ROW_VOXEL, '0, 32'ha5a5a500, '0},
		'{ROW_REG, CFG_EXTENT_X, 32'd3, '0},
		'{ROW_REG, CFG_EXTENT_Y, 32'd1, '0},
		'{ROW_REG, CFG_EXTENT_Z, 32'd1, '0},
		'{ROW_VOXEL, '0, 32'hfe0180c0, '0},
		'{ROW_VOXEL, '0, 32'h55aa55ff, '0},
		'{ROW_VOXEL, '0, 32'haa55aaff, '0},
		'{ROW_VOXEL, '0, 32'h00ff0001, '0},
		'{ROW_REG, CFG_EXTENT_X, 32'd511, '0},
		'{ROW_REG, CFG_EXTENT_Y, 32'd256, '0},
		'{ROW_REG, CFG_EXTENT_Z, 32'd256, '0},
		'{ROW_VOXEL, '0, 32'h0f0f0f10, '0},
		'{ROW_VOXEL, '0, 32'hf0f0f0ef, '0},
		'{ROW_VOXEL, '0, 32'h000000ff, '0}
	};

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	vpi_in_if  voxel ();
	vpi_out_if result ();

	voxel_palette_indexer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.voxel     (voxel),
		.result    (result)
	);

	// Model state: palette contents, fill pointer, scan position, sticky error.
	logic [23:0] pal_rgb [1:PALETTE_SLOTS];
	int unsigned pal_fill = 1;
	logic [7:0]  pos_x = '0;
	logic [7:0]  pos_y = '0;
	logic [7:0]  pos_z = '0;
	logic        full_seen = 1'b0;
	logic        swap_rb = 1'b0;
	logic [8:0]  ext_x = 9'd1;
	logic [8:0]  ext_y = 9'd1;
	logic [8:0]  ext_z = 9'd1;

	voxel_result_t results_due [$];
	typed_result_t typed_results [$];
	logic [23:0]   color_pool [POOL_COLORS];
	int            errors = 0;
	bit            steady = 1'b0;
	bit            hold_request = 1'b0;

	function automatic int unsigned fit_extent(logic [8:0] e);
		if (e == 0)
			return 1;
		if (e > MAX_EXTENT)
			return MAX_EXTENT;
		return e;
	endfunction

	function automatic voxel_result_t predict_palette_result(logic [7:0] r_in, g_in, b_in,
			a_in);
		voxel_result_t res;
		int unsigned ex, ey, ez, hit;
		logic [7:0] r, b;
		logic [23:0] rgb;
		logic lx, ly, lz;
		res = '0;
		ex = fit_extent(ext_x);
		ey = fit_extent(ext_y);
		ez = fit_extent(ext_z);
		res.address = 24'(pos_x * ey * ez + pos_y * ez + pos_z);
		lx = (int'(pos_x) + 1 >= ex);
		ly = (int'(pos_y) + 1 >= ey);
		lz = (int'(pos_z) + 1 >= ez);
		if (a_in != 0 && !full_seen) begin
			r = swap_rb ? b_in : r_in;
			b = swap_rb ? r_in : b_in;
			rgb = {r, g_in, b};
			hit = 0;
			for (int i = 1; i < pal_fill && i <= PALETTE_SLOTS; i++)
				if (hit == 0 && pal_rgb[i] == rgb)
					hit = i;
			if (hit == 0) begin
				if (pal_fill > PALETTE_SLOTS) begin
					full_seen = 1'b1;
				end else begin
					hit = pal_fill;
					pal_rgb[hit] = rgb;
					pal_fill++;
					res.fresh = 1'b1;
				end
			end
			if (hit != 0) begin
				res.store = 1'b1;
				res.index = 8'(hit);
				res.red = r;
				res.green = g_in;
				res.blue = b;
			end
		end
		res.full = full_seen;
		res.last = lx && ly && lz;
		if (!lx) begin
			pos_x = pos_x + 1;
		end else begin
			pos_x = '0;
			if (!ly) begin
				pos_y = pos_y + 1;
			end else begin
				pos_y = '0;
				pos_z = lz ? 8'd0 : pos_z + 1;
			end
		end
		return res;
	endfunction

	function automatic logic [8:0] pick_extent();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 55)
			return 9'($urandom_range(1, 5));
		if (k < 65)
			return 9'd0;
		if (k < 75)
			return 9'd256;
		if (k < 87)
			return 9'($urandom_range(257, 511));
		return 9'($urandom_range(6, 255));
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [8:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_voxel(logic [7:0] r, g, b, a);
		while (!steady && $urandom_range(99) < 30) begin
			voxel.valid <= 1'b0;
			@(posedge clk);
		end
		voxel.valid <= 1'b1;
		voxel.red <= r;
		voxel.green <= g;
		voxel.blue <= b;
		voxel.alpha <= a;
		@(posedge clk);
		while (!voxel.ready)
			@(posedge clk);
	endtask

	task automatic settle_idle();
		voxel.valid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin : scoreboard
		voxel_result_t want;
		voxel_result_t got;
		typed_result_t row;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_SWAP_RED_BLUE: swap_rb = cfg_data[0];
					CFG_EXTENT_X: ext_x = cfg_data;
					CFG_EXTENT_Y: ext_y = cfg_data;
					CFG_EXTENT_Z: ext_z = cfg_data;
					default: ;
				endcase
			end
			if (voxel.valid && voxel.ready) begin
				want = predict_palette_result(voxel.red, voxel.green, voxel.blue,
					voxel.alpha);
				if (typed_results.size() != 0) begin
					row = typed_results.pop_front();
					if (row.typed)
						want = row.want;
				end
				results_due.push_back(want);
			end
			if (result.valid && result.ready) begin
				got = '{result.store, result.voxel_address, result.palette_index,
					result.new_entry, result.entry_red, result.entry_green,
					result.entry_blue, result.palette_full, result.last_voxel};
				if (results_due.size() == 0) begin
					if (errors < 10)
						$display("result beat with nothing expected at %0t", $realtime);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (got.store !== want.store || got.address !== want.address ||
							got.index !== want.index || got.fresh !== want.fresh ||
							got.red !== want.red || got.green !== want.green ||
							got.blue !== want.blue || got.full !== want.full ||
							got.last !== want.last) begin
						if (errors < 10) begin
							$display("mismatch at %0t: want store=%0b addr=%06h idx=%0d new=%0b",
								$realtime, want.store, want.address, want.index, want.fresh,
								" rgb=%02h%02h%02h full=%0b last=%0b", want.red, want.green,
								want.blue, want.full, want.last);
							$display("  got store=%0b addr=%06h idx=%0d new=%0b", got.store,
								got.address, got.index, got.fresh,
								" rgb=%02h%02h%02h full=%0b last=%0b", got.red, got.green,
								got.blue, got.full, got.last);
						end
						errors++;
					end
				end
			end
		end
	end

	initial begin
		result.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				result.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			result.ready <= steady || ($urandom_range(99) >= 30);
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d result beats outstanding", cycles,
			results_due.size());
		$display("FAIL voxel_palette_indexer");
		$finish;
	end

	initial begin
		int unsigned items, k, fresh_pct;
		logic [23:0] rgb;
		logic [7:0] a;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		voxel.valid <= 1'b0;
		voxel.red <= '0;
		voxel.green <= '0;
		voxel.blue <= '0;
		voxel.alpha <= '0;
		foreach (color_pool[i])
			color_pool[i] = 24'($urandom);
		color_pool[0] = 24'h000000;
		color_pool[1] = 24'hffffff;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[n]) begin
			if (directed_rows[n].kind == ROW_REG) begin
				settle_idle();
				write_reg(directed_rows[n].reg_idx, directed_rows[n].payload[8:0]);
			end else begin
				typed_results.push_back('{directed_rows[n].kind == ROW_TYPED,
					directed_rows[n].want});
				send_voxel(directed_rows[n].payload[31:24], directed_rows[n].payload[23:16],
					directed_rows[n].payload[15:8], directed_rows[n].payload[7:0]);
			end
		end

		// Colors come mostly from a small pool so that the palette fills slowly
		// and most beats hit an existing entry; the last phase overflows it.
		for (int phase = 0; phase < PHASES; phase++) begin
			settle_idle();
			write_reg(CFG_SWAP_RED_BLUE, 9'($urandom_range(0, 511)));
			write_reg(CFG_EXTENT_X, phase == 0 ? 9'd256 : pick_extent());
			write_reg(CFG_EXTENT_Y, phase == 0 ? 9'd256 : pick_extent());
			write_reg(CFG_EXTENT_Z, phase == 0 ? 9'd256 : pick_extent());
			if (phase == 0 || phase == PHASES - 1)
				items = 260;
			else if (phase == STEADY_PHASE)
				items = 100;
			else if (phase == HOLD_PHASE)
				items = 300;
			else
				items = $urandom_range(20, 60);
			fresh_pct = (phase == PHASES - 1) ? 70 : 2;
			steady = (phase == STEADY_PHASE);
			if (phase == HOLD_PHASE)
				hold_request = 1'b1;
			repeat (items) begin
				k = $urandom_range(99);
				rgb = color_pool[$urandom_range(POOL_COLORS - 1)];
				a = 8'($urandom_range(1, 255));
				if (k < 8) begin
					rgb = 24'($urandom);
					a = 8'd0;
				end else if (k < 8 + fresh_pct) begin
					rgb = 24'($urandom);
				end
				send_voxel(rgb[23:16], rgb[15:8], rgb[7:0], a);
			end
			steady = 1'b0;
		end

		settle_idle();
		repeat (PALETTE_SLOTS + 16) @(posedge clk);
		if (results_due.size() != 0) begin
			$display("%0d expected result beats never arrived", results_due.size());
			errors += results_due.size();
		end
		if (errors == 0)
			$display("PASS voxel_palette_indexer");
		else
			$display("FAIL voxel_palette_indexer");
		$finish;
	end

endmodule
